// ===== rtl/core/ssc_pkg.sv =====
// Shared types and constants for the sentence span scanner.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package ssc_pkg;

  // Beat presented on the input queue side
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_beat_t;

  // Beat presented on the result queue side
  typedef struct packed {
    logic        span_valid;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic        buffer_done;
  } out_beat_t;

  // Byte classes decoded by the front end
  typedef struct packed {
    logic ws;        // space, tab, newline, carriage return
    logic nl;        // newline
    logic term1;     // . ! ?
    logic close1;    // " ' ) ]
    logic lead_e2;   // first byte of E2 80 xx
    logic cont_80;   // second byte of E2 80 xx
    logic ell_a6;    // ellipsis tail
    logic quote_tail; // curly closing quote tails 9D, 99
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic        last_byte;
  } cls_beat_t;

  // Command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Result queue inside the back end
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_BASE_OFFSET = 1'b0;
  localparam logic CFG_MAX_SPANS   = 1'b1;

  localparam logic [7:0] BYTE_E2 = 8'hE2;
  localparam logic [7:0] BYTE_80 = 8'h80;
  localparam logic [7:0] BYTE_A6 = 8'hA6;
  localparam logic [7:0] BYTE_9D = 8'h9D;
  localparam logic [7:0] BYTE_99 = 8'h99;

  // Scanner phase
  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_SENT = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  // Progress through an E2 80 xx sequence
  typedef enum logic [1:0] {
    MATCH_NONE = 2'd0,
    MATCH_E2   = 2'd1,
    MATCH_E280 = 2'd2
  } match_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c.nl         = (b == 8'h0A);
    c.ws         = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    c.term1      = (b == 8'h2E) || (b == 8'h21) || (b == 8'h3F);
    c.close1     = (b == 8'h22) || (b == 8'h27) || (b == 8'h29) || (b == 8'h5D);
    c.lead_e2    = (b == BYTE_E2);
    c.cont_80    = (b == BYTE_80);
    c.ell_a6     = (b == BYTE_A6);
    c.quote_tail = (b == BYTE_9D) || (b == BYTE_99);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssc_front.sv =====
// Front end: input queue handshake, byte classification, one holding stage.
// Depends on ssc_pkg; feeds ssc_queue.
`default_nettype none

module ssc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output      logic              full,
  input  wire ssc_pkg::in_beat_t item,
  output      logic              q_push,
  output      ssc_pkg::cls_beat_t q_beat,
  input  wire logic              q_full
);
  import ssc_pkg::*;

  logic      hold_valid;
  cls_beat_t hold;
  logic      accept;

  // Stage frees up in the same cycle it drains into the queue
  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_push = hold_valid && !q_full;
  assign q_beat = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept || (hold_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.cls       <= classify(item.text_byte);
      hold.last_byte <= item.last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssc_queue.sv =====
// Short command queue of classified beats between front and back.
// Depends on ssc_pkg.
`default_nettype none

module ssc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire ssc_pkg::cls_beat_t wr_beat,
  output      logic               q_full,
  input  wire logic               rd_en,
  output      ssc_pkg::cls_beat_t rd_beat,
  output      logic               q_empty
);
  import ssc_pkg::*;

  cls_beat_t          slots [CQ_DEPTH];
  logic [CQ_AW-1:0]   wr_ptr;
  logic [CQ_AW-1:0]   rd_ptr;
  logic [CQ_CW-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (count == CQ_CW'(CQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_beat = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_beat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssc_back.sv =====
// Back end: sentence scanner state, span offsets and the result queue.
// Depends on ssc_pkg; drains ssc_queue.
`default_nettype none

module ssc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire ssc_pkg::cls_beat_t q_beat,
  output      logic               q_pop,
  input  wire logic [31:0]        base_offset,
  input  wire logic [15:0]        max_spans,
  output      logic               empty,
  input  wire logic               pop,
  output      ssc_pkg::out_beat_t result
);
  import ssc_pkg::*;

  // Scanner state
  phase_t      phase;
  match_t      match;
  logic [31:0] byte_pos;
  logic [31:0] cur_start;
  logic [31:0] trim_end;
  logic [15:0] span_cnt;
  logic        limit_hit;

  phase_t      phase_next;
  match_t      match_next;
  logic [31:0] cur_start_next;
  logic [31:0] trim_end_next;
  logic [15:0] span_cnt_next;
  logic        limit_next;

  logic        lim;
  logic        fresh;
  logic        ended;
  logic [31:0] end_pos;
  logic [31:0] pos_inc;
  logic        out_push;
  out_beat_t   out_new;
  byte_class_t c;
  logic        last;

  // Result queue
  out_beat_t        oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr;
  logic [OQ_AW-1:0] oq_rd;
  logic [OQ_CW-1:0] oq_cnt;
  logic             oq_pop;
  logic             oq_space;
  logic             step;

  assign c        = q_beat.cls;
  assign last     = q_beat.last_byte;
  assign empty    = (oq_cnt == '0);
  assign oq_pop   = pop && !empty;
  assign oq_space = (oq_cnt != OQ_CW'(OQ_DEPTH)) || oq_pop;
  assign step     = !q_empty && oq_space;
  assign q_pop    = step;
  assign result   = oq[oq_rd];
  assign pos_inc  = byte_pos + 32'd1;
  assign lim      = limit_hit || (span_cnt >= max_spans);

  always_comb begin
    phase_next     = phase;
    match_next     = match;
    cur_start_next = cur_start;
    trim_end_next  = trim_end;
    ended          = 1'b0;
    end_pos        = '0;
    fresh          = 1'b0;
    if (!lim) begin
      unique case (phase)
        PH_SENT: begin
          if (match == MATCH_E2 && c.cont_80) begin
            match_next    = MATCH_E280;
            trim_end_next = pos_inc;
          end else if (match == MATCH_E280 && c.ell_a6) begin
            match_next    = MATCH_NONE;
            phase_next    = PH_RUN;
            trim_end_next = pos_inc;
          end else begin
            match_next = MATCH_NONE;
            fresh      = 1'b1;
          end
        end
        PH_RUN: begin
          if (match == MATCH_E2) begin
            if (c.cont_80) begin
              match_next    = MATCH_E280;
              trim_end_next = pos_inc;
            end else begin
              match_next = MATCH_NONE;
              phase_next = PH_SENT;
              fresh      = 1'b1;
            end
          end else if (match == MATCH_E280) begin
            match_next = MATCH_NONE;
            if (c.ell_a6 || c.quote_tail) begin
              trim_end_next = pos_inc;
            end else begin
              phase_next = PH_SENT;
              fresh      = 1'b1;
            end
          end else if (c.term1 || c.close1) begin
            trim_end_next = pos_inc;
          end else if (c.lead_e2) begin
            match_next    = MATCH_E2;
            trim_end_next = pos_inc;
          end else if (c.ws) begin
            ended      = 1'b1;
            end_pos    = byte_pos;
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_SENT;
            fresh      = 1'b1;
          end
        end
        default: begin
          match_next = MATCH_NONE;
          if (!c.ws) begin
            phase_next     = PH_SENT;
            cur_start_next = byte_pos;
            fresh          = 1'b1;
          end
        end
      endcase

      // In-sentence handling with no partial sequence pending
      if (fresh) begin
        if (c.nl) begin
          ended      = 1'b1;
          end_pos    = byte_pos;
          phase_next = PH_SKIP;
        end else begin
          if (!c.ws) trim_end_next = pos_inc;
          if (c.term1) phase_next = PH_RUN;
          else if (c.lead_e2) match_next = MATCH_E2;
        end
      end

      // Unterminated tail at buffer end
      if (!ended && last && phase_next != PH_SKIP) begin
        ended   = 1'b1;
        end_pos = trim_end_next;
      end
    end

    span_cnt_next = ended ? span_cnt + 16'd1 : span_cnt;
    limit_next    = lim || (ended && (span_cnt_next >= max_spans));

    out_push            = ended || last;
    out_new.span_valid  = ended;
    out_new.span_start  = ended ? base_offset + cur_start_next : '0;
    out_new.span_end    = ended ? base_offset + end_pos : '0;
    out_new.buffer_done = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SKIP;
      match     <= MATCH_NONE;
      byte_pos  <= '0;
      cur_start <= '0;
      trim_end  <= '0;
      span_cnt  <= '0;
      limit_hit <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase     <= PH_SKIP;
        match     <= MATCH_NONE;
        byte_pos  <= '0;
        cur_start <= '0;
        trim_end  <= '0;
        span_cnt  <= '0;
        limit_hit <= 1'b0;
      end else begin
        phase     <= phase_next;
        match     <= match_next;
        byte_pos  <= pos_inc;
        cur_start <= cur_start_next;
        trim_end  <= trim_end_next;
        span_cnt  <= span_cnt_next;
        limit_hit <= limit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (step && out_push) oq_wr <= oq_wr + 1'b1;
      if (oq_pop) oq_rd <= oq_rd + 1'b1;
      if ((step && out_push) && !oq_pop) oq_cnt <= oq_cnt + 1'b1;
      else if (oq_pop && !(step && out_push)) oq_cnt <= oq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && out_push) begin
      oq[oq_wr] <= out_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sentence_span_scanner.sv =====
// Top level of the sentence span scanner: config registers and the
// front / command queue / back chain. Depends on ssc_pkg, ssc_front,
// ssc_queue and ssc_back.
//
//   channel   | handshake                  | beat
//   ----------+----------------------------+-----------------------------------
//   input     | push / full                | item   : text_byte, last_byte
//   result    | empty / pop                | result : span_valid, span_start,
//             |                            |          span_end, buffer_done
//   config    | cfg_we (no wait)           | cfg_index, cfg_data
//
// One byte per cycle sustained while the result side keeps popping. From
// accept to result a byte passes the front holding stage, the command queue
// and the scanner step writing the result queue. Front and back stall
// independently through the 4-deep command queue; the 2-deep result queue
// lets the scanner keep going while a result waits. Reset (rst, synchronous)
// empties both queues and returns the scanner to whitespace skipping;
// base_offset resets to 0, max_spans to 65535. Bytes that produce no result just advance the scanner.
`default_nettype none

module sentence_span_scanner (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output      logic               full,
  input  wire ssc_pkg::in_beat_t  item,
  output      logic               empty,
  input  wire logic               pop,
  output      ssc_pkg::out_beat_t result,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import ssc_pkg::*;

  logic [31:0] base_offset;
  logic [15:0] max_spans;

  logic      fq_push;
  cls_beat_t fq_beat;
  logic      fq_full;
  logic      bq_pop;
  cls_beat_t bq_beat;
  logic      bq_empty;

  // User must write config only while idle; no scanner interlock enforces it
  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
      max_spans   <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_OFFSET: base_offset <= cfg_data;
        CFG_MAX_SPANS:   max_spans   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ssc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (fq_push),
    .q_beat (fq_beat),
    .q_full (fq_full)
  );

  ssc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_beat (fq_beat),
    .q_full  (fq_full),
    .rd_en   (bq_pop),
    .rd_beat (bq_beat),
    .q_empty (bq_empty)
  );

  ssc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (bq_empty),
    .q_beat      (bq_beat),
    .q_pop       (bq_pop),
    .base_offset (base_offset),
    .max_spans   (max_spans),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== verif/tb_sentence_span_scanner.sv =====
// Self-checking testbench for sentence_span_scanner: random and directed UTF-8 text
// buffers, a beat-level predictor of the span scanner, and queue-style handshakes.
// Depends on rtl/core/ssc_pkg.sv and the sentence_span_scanner RTL.
`timescale 1ns / 100ps

module tb_sentence_span_scanner;
  import ssc_pkg::*;

  // ASCII bytes the scanner cares about
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_A_LC  = 8'h61;

  localparam int unsigned GAP_MAX     = 18;   // longest per-beat wait on either side
  localparam int unsigned HOLD_CYCLES = 250;  // one long receiver hold-off
  localparam int unsigned SETTLE      = 8;    // settling margin after drain

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        push = 1'b0;
  logic        full;
  in_beat_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_beat_t   result;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'h0;

  sentence_span_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner predictor: own copy of registers and per-buffer state
  // ---------------------------------------------------------------------------
  logic [31:0] base_reg  = 32'h0;
  logic [15:0] limit_reg = 16'hFFFF;

  phase_t      ph        = PH_SKIP;
  match_t      mt        = MATCH_NONE;
  logic [31:0] pos       = '0;
  logic [31:0] start_pos = '0;
  logic [31:0] trim_end  = '0;
  logic [15:0] n_spans   = '0;
  bit          at_limit  = 1'b0;

  // set by the scan step when the current byte closes a span
  bit          span_closed;
  logic [31:0] close_at;

  out_beat_t   spans_due [$];     // expected result beats, oldest first
  in_beat_t    bytes_waiting [$]; // input beats not yet offered
  logic [7:0]  text_buf [$];      // buffer under construction

  int unsigned mismatches = 0;

  function automatic bit is_space(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR;
  endfunction

  function automatic bit is_stop(input logic [7:0] b);
    return b == CH_DOT || b == CH_BANG || b == CH_QMARK;
  endfunction

  function automatic bit is_closer(input logic [7:0] b);
    return b == CH_DQ || b == CH_SQ || b == CH_RPAR || b == CH_RBRK;
  endfunction

  // In-sentence handling of a byte with no partial E2 80 match pending
  task automatic in_sentence(input logic [7:0] b, input logic [31:0] p);
    if (b == CH_NL) begin
      span_closed = 1'b1;
      close_at    = p;
      ph          = PH_SKIP;
    end else begin
      if (!is_space(b)) trim_end = p + 32'd1;
      if (is_stop(b)) ph = PH_RUN;
      else if (b == BYTE_E2) mt = MATCH_E2;
    end
  endtask

  task automatic advance(input logic [7:0] b, input logic [31:0] p);
    match_t m;
    m = mt;
    case (ph)
      PH_SENT: begin
        if (m == MATCH_E2 && b == BYTE_80) begin
          mt       = MATCH_E280;
          trim_end = p + 32'd1;
        end else if (m == MATCH_E280 && b == BYTE_A6) begin
          // ellipsis opens a terminator run
          mt       = MATCH_NONE;
          ph       = PH_RUN;
          trim_end = p + 32'd1;
        end else begin
          // broken prefix counts as text; this byte is looked at afresh
          mt = MATCH_NONE;
          in_sentence(b, p);
        end
      end
      PH_RUN: begin
        if (m == MATCH_E2) begin
          if (b == BYTE_80) begin
            mt       = MATCH_E280;
            trim_end = p + 32'd1;
          end else begin
            mt = MATCH_NONE;
            ph = PH_SENT;
            in_sentence(b, p);
          end
        end else if (m == MATCH_E280) begin
          mt = MATCH_NONE;
          if (b == BYTE_A6 || b == BYTE_9D || b == BYTE_99) begin
            trim_end = p + 32'd1;
          end else begin
            ph = PH_SENT;
            in_sentence(b, p);
          end
        end else if (is_stop(b) || is_closer(b)) begin
          trim_end = p + 32'd1;
        end else if (b == BYTE_E2) begin
          mt       = MATCH_E2;
          trim_end = p + 32'd1;
        end else if (is_space(b)) begin
          span_closed = 1'b1;
          close_at    = p;
          ph          = PH_SKIP;
        end else begin
          ph = PH_SENT;
          in_sentence(b, p);
        end
      end
      default: begin
        mt = MATCH_NONE;
        if (!is_space(b)) begin
          ph        = PH_SENT;
          start_pos = p;
          in_sentence(b, p);
        end
      end
    endcase
  endtask

  // One accepted input beat: update state, queue the result beat it causes
  task automatic step_scanner(input in_beat_t it);
    logic [31:0] p;
    out_beat_t   r;
    bit          hit;
    p   = pos;
    r   = '0;
    hit = 1'b0;
    if (n_spans >= limit_reg) at_limit = 1'b1;
    if (!at_limit) begin
      span_closed = 1'b0;
      close_at    = '0;
      advance(it.text_byte, p);
      // unterminated tail at buffer end
      if (!span_closed && it.last_byte && ph != PH_SKIP) begin
        span_closed = 1'b1;
        close_at    = trim_end;
      end
      if (span_closed) begin
        hit          = 1'b1;
        r.span_start = base_reg + start_pos;
        r.span_end   = base_reg + close_at;
        n_spans      = n_spans + 16'd1;
        if (n_spans >= limit_reg) at_limit = 1'b1;
      end
    end
    pos = p + 32'd1;
    if (hit || it.last_byte) begin
      r.span_valid  = hit;
      r.buffer_done = it.last_byte;
      spans_due.insert(spans_due.size(), r);
    end
    if (it.last_byte) begin
      ph        = PH_SKIP;
      mt        = MATCH_NONE;
      pos       = '0;
      start_pos = '0;
      trim_end  = '0;
      n_spans   = '0;
      at_limit  = 1'b0;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns  MISMATCH %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: config mirror, input accept, result check
  // ---------------------------------------------------------------------------
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;

  always @(posedge clk) begin
    out_beat_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_OFFSET: base_reg  = cfg_data;
          CFG_MAX_SPANS:   limit_reg = cfg_data[15:0];
        endcase
      end
      if (push && !full) begin
        in_taken = 1'b1;
        step_scanner(item);
      end
      if (pop && !empty) begin
        out_taken = 1'b1;
        if (spans_due.size() == 0) begin
          report("result beat with nothing expected, span_start", result.span_start, '0);
        end else begin
          want = spans_due.pop_front();
          if (result.span_valid !== want.span_valid)
            report("span_valid", result.span_valid, want.span_valid);
          if (result.span_start !== want.span_start)
            report("span_start", result.span_start, want.span_start);
          if (result.span_end !== want.span_end)
            report("span_end", result.span_end, want.span_end);
          if (result.buffer_done !== want.buffer_done)
            report("buffer_done", result.buffer_done, want.buffer_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued beats at the falling edge with random gaps
  // ---------------------------------------------------------------------------
  int unsigned send_gap_max = 0;
  int unsigned send_wait    = 0;

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (send_wait != 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (bytes_waiting.size() != 0) begin
        item      <= bytes_waiting.pop_front();
        push      <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop stalls, plus one long hold-off so the block fills up
  // and pushes back on the input side
  // ---------------------------------------------------------------------------
  int unsigned recv_stall_max = 0;
  int unsigned recv_wait      = 0;
  int unsigned hold_left      = 0;
  bit          squeeze        = 1'b0;  // raised by the stimulus process
  bit          squeezed       = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (squeeze && !squeezed) begin
      squeezed  = 1'b1;
      hold_left = HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (!pop || out_taken) begin
      if (recv_wait != 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop       <= 1'b1;
        recv_wait = $urandom_range(0, recv_stall_max);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Append one byte to the buffer under construction
  task automatic add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  // Move text_buf into the input queue, marking its final byte
  task automatic queue_buffer();
    in_beat_t beat;
    foreach (text_buf[i]) begin
      beat.text_byte = text_buf[i];
      beat.last_byte = (i == text_buf.size() - 1);
      bytes_waiting.insert(bytes_waiting.size(), beat);
    end
  endtask

  // Mostly sentence-like text with random content; some buffers pure noise
  task automatic compose_buffer();
    int unsigned len;
    int unsigned r;
    bit          noise;
    noise = ($urandom_range(0, 7) == 0);
    if (noise) len = $urandom_range(1, 12);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 120);
    else len = $urandom_range(1, 40);
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(0, 99);
      if (noise || r >= 88) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (r < 40) begin
        add_byte(CH_A_LC + 8'($urandom_range(0, 25)));
      end else if (r < 52) begin
        add_byte(CH_SPACE);
      end else if (r < 58) begin
        case ($urandom_range(0, 2))
          0:       add_byte(CH_DOT);
          1:       add_byte(CH_BANG);
          default: add_byte(CH_QMARK);
        endcase
      end else if (r < 63) begin
        case ($urandom_range(0, 3))
          0:       add_byte(CH_DQ);
          1:       add_byte(CH_SQ);
          2:       add_byte(CH_RPAR);
          default: add_byte(CH_RBRK);
        endcase
      end else if (r < 67) begin
        add_byte(CH_NL);
      end else if (r < 70) begin
        add_byte($urandom_range(0, 1) ? CH_TAB : CH_CR);
      end else if (r < 76) begin
        // ellipsis
        add_byte(BYTE_E2);
        add_byte(BYTE_80);
        add_byte(BYTE_A6);
      end else if (r < 82) begin
        // curly closing quote
        add_byte(BYTE_E2);
        add_byte(BYTE_80);
        add_byte($urandom_range(0, 1) ? BYTE_9D : BYTE_99);
      end else begin
        // prefix that is never completed
        add_byte(BYTE_E2);
        if ($urandom_range(0, 1)) add_byte(BYTE_80);
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    queue_buffer();
  endtask

  // Everything offered, accepted and checked, then let the pipeline settle
  task automatic wait_drained();
    while (bytes_waiting.size() != 0 || push || spans_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [15:0] limit,
                           input int unsigned send_max, input int unsigned recv_max,
                           input int unsigned n_items, input bit hold_off);
    int unsigned added;
    wait_drained();
    write_reg(CFG_BASE_OFFSET, base);
    write_reg(CFG_MAX_SPANS, {16'h0, limit});
    @(posedge clk);
    send_gap_max   = send_max;
    recv_stall_max = recv_max;
    if (hold_off) squeeze = 1'b1;
    added = 0;
    while (added < n_items) begin
      compose_buffer();
      added += text_buf.size();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text under reset register values. First buffer: leading space,
    // terminator plus closer before a space, ellipsis before a newline, a
    // broken E2 prefix, an unmatched curly tail inside a sentence, a dot
    // inside a number, and an E2 80 prefix cut off by the buffer end.
    send_gap_max   = GAP_MAX;
    recv_stall_max = GAP_MAX;
    text_buf = '{CH_SPACE, 8'h41, CH_DOT, CH_RPAR, CH_SPACE, 8'h62,
                 BYTE_E2, BYTE_80, BYTE_A6, CH_NL, 8'h63, BYTE_E2, 8'h41,
                 BYTE_E2, BYTE_80, BYTE_9D, CH_TAB, 8'h33, CH_DOT, 8'h31,
                 BYTE_E2, BYTE_80};
    queue_buffer();
    // byte extremes, then a whitespace-only buffer that gives no span
    text_buf = '{8'h00, 8'hFF};
    queue_buffer();
    text_buf = '{CH_CR};
    queue_buffer();

    // base, limit, sender gap, receiver stall, items, long hold-off
    run_phase(32'h0000_1000, 16'hFFFF, GAP_MAX, GAP_MAX, 300, 1'b0);
    run_phase(32'hFFFF_FFF0, 16'd3,    0,       0,       200, 1'b0);  // wraps, no idling
    run_phase(32'hFFFF_FFFF, 16'd0,    GAP_MAX, 0,        60, 1'b0);  // no spans at all
    run_phase($urandom,      16'd1,    0,       GAP_MAX, 200, 1'b0);
    run_phase(32'h0,         16'hFFFF, 0,       GAP_MAX, 250, 1'b1);  // fill and stall
    run_phase($urandom,      16'd2,    GAP_MAX, GAP_MAX, 200, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, GAP_MAX, 0,       215, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ssc_pkg.sv
rtl/core/ssc_front.sv
rtl/core/ssc_queue.sv
rtl/core/ssc_back.sv
rtl/core/sentence_span_scanner.sv
verif/tb_sentence_span_scanner.sv
